// ----- rtl/pttlm_pkg.sv -----
package pttlm_pkg;

   // field widths
   localparam int PEDAL_W = 10;
   localparam int LEVEL_W = 12;
   localparam int WIDE_W  = 22;
   localparam int QBITS   = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // level limits
   localparam int LIMIT_HI  = 1050;
   localparam int LIMIT_LO  = -1050;
   localparam int SNAP_FROM = 979;
   localparam int FULL_LVL  = 1000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REGEN_FULL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REGEN_LIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_ONE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_TWO     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_THREE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CREEP       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_REGEN_PCT   = 3'd7;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_CREEP,
      KIND_REGEN,
      KIND_DRIVE
   } kind_type;

   // what travels beside the divider
   typedef struct packed {
      kind_type            kind;
      logic [9:0]          y0;
      logic [10:0]         creep_lvl;
      logic signed [7:0]   rdiff;
      logic [6:0]          rlo;
   } side_type;

   typedef struct packed {
      logic [QBITS-1:0] work;
      logic [9:0]       rem;
      logic [9:0]       den;
      logic             qneg;
      side_type         side;
   } div_type;

endpackage

// ----- rtl/pedal_to_torque_level_map_core.sv -----
// Pedal to torque level map. Each pedal sample (tdata: pedal permille, tuser: signal valid
// flag) yields one signed torque level in permille and the sticky fault flag. Samples flow
// through a fixed pipeline of 26 register stages: decode, multiply, a 21-stage restoring
// divider that retires one quotient bit per stage, two regen scaling stages and the output
// register. One sample is accepted every cycle unless rsp stalls, which freezes the whole
// pipeline. Registers are written through the csr port, which is always ready; the user
// must write them only while no sample is in flight, as the block does not enforce it.
module pedal_to_torque_level_map_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // [9:0] pedal_position
   input  logic [0:0]                         req_tuser,   // [0] signal_valid
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [11:0] torque_level
   output logic [0:0]                         rsp_tuser,   // [0] fault_seen
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pttlm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pttlm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import pttlm_pkg::*;

   // configuration registers
   logic [9:0]  rfull_ff, rlight_ff, dstart_ff;
   logic [19:0] mp1_ff, mp2_ff, mp3_ff;
   logic [6:0]  creep_ff;
   logic [13:0] rpct_ff;
   logic        fault_ff;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rfull_ff  <= 10'd0;
         rlight_ff <= 10'd270;
         dstart_ff <= 10'd280;
         mp1_ff    <= 20'd768500;
         mp2_ff    <= 20'd768500;
         mp3_ff    <= 20'd768500;
         creep_ff  <= 7'd0;
         rpct_ff   <= 14'd8960;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_REGEN_FULL:  rfull_ff  <= csr_data[9:0];
            REG_REGEN_LIGHT: rlight_ff <= csr_data[9:0];
            REG_DRIVE_START: dstart_ff <= csr_data[9:0];
            REG_MAP_ONE:     mp1_ff    <= csr_data;
            REG_MAP_TWO:     mp2_ff    <= csr_data;
            REG_MAP_THREE:   mp3_ff    <= csr_data;
            REG_CREEP:       creep_ff  <= csr_data[6:0];
            REG_REGEN_PCT:   rpct_ff   <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage a: decode zone and segment
   logic [9:0]         a_dx_in, a_den_in;
   logic signed [10:0] a_dy_in;
   logic               a_neg_in;
   side_type           a_side_in;

   always_comb begin
      logic [9:0]         p, x0, x1, y0, y1;
      logic signed [10:0] span_f, span_r;
      logic               creep_hit, regen_hit, drive_hit;
      p         = req_tdata[9:0];
      creep_hit = (p == 10'd0) && (creep_ff != 7'd0);
      regen_hit = (p <= rlight_ff) && (p >= rfull_ff);
      drive_hit = (p >= dstart_ff);
      span_r    = $signed({1'b0, rlight_ff}) - $signed({1'b0, rfull_ff});
      // pick the last segment whose guard holds
      x0 = dstart_ff;      x1 = mp1_ff[19:10]; y0 = 10'd0;         y1 = mp1_ff[9:0];
      if (p >= mp1_ff[19:10] && mp2_ff[19:10] > mp1_ff[19:10]) begin
         x0 = mp1_ff[19:10]; x1 = mp2_ff[19:10]; y0 = mp1_ff[9:0]; y1 = mp2_ff[9:0];
      end
      if (p >= mp2_ff[19:10] && mp3_ff[19:10] > mp2_ff[19:10]) begin
         x0 = mp2_ff[19:10]; x1 = mp3_ff[19:10]; y0 = mp2_ff[9:0]; y1 = mp3_ff[9:0];
      end
      if (p >= mp3_ff[19:10] && mp3_ff[19:10] < 10'(FULL_LVL)) begin
         x0 = mp3_ff[19:10]; x1 = 10'(FULL_LVL); y0 = mp3_ff[9:0]; y1 = 10'(FULL_LVL);
      end
      span_f = $signed({1'b0, x1}) - $signed({1'b0, x0});

      a_side_in.kind      = KIND_ZERO;
      a_side_in.y0        = y0;
      a_side_in.creep_lvl = 11'(creep_ff) * 11'd10;
      a_side_in.rdiff     = $signed({1'b0, rpct_ff[13:7]}) - $signed({1'b0, rpct_ff[6:0]});
      a_side_in.rlo       = rpct_ff[6:0];
      // regen: offset times 100 over the zone span
      a_dx_in  = p - rfull_ff;
      a_dy_in  = 11'sd100;
      a_den_in = span_r[9:0];
      a_neg_in = 1'b0;
      if (creep_hit)
         a_side_in.kind = KIND_CREEP;
      else if (regen_hit && span_r != 11'sd0)
         a_side_in.kind = KIND_REGEN;
      if (drive_hit) begin
         a_side_in.kind = (span_f != 11'sd0) ? KIND_DRIVE : KIND_ZERO;
         a_dx_in  = p - x0;
         a_dy_in  = $signed({1'b0, y1}) - $signed({1'b0, y0});
         a_neg_in = span_f < 0;
         a_den_in = a_neg_in ? 10'(-span_f) : span_f[9:0];
      end
      if (!req_tuser[0])
         a_side_in.kind = KIND_ZERO;
   end

   logic               a_vld_ff;
   logic [9:0]         a_dx_ff, a_den_ff;
   logic signed [10:0] a_dy_ff;
   logic               a_neg_ff;
   side_type           a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (adv) a_vld_ff <= req_tvalid;
      if (adv) begin
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_den_ff  <= a_den_in;
         a_neg_ff  <= a_neg_in;
         a_side_ff <= a_side_in;
      end
   end

   // ---------------- stage b: numerator product and sign split
   div_type            b_in;
   logic signed [21:0] b_prod;

   always_comb begin
      b_prod      = $signed({1'b0, a_dx_ff}) * a_dy_ff;
      b_in.work   = (b_prod < 0) ? QBITS'(-b_prod) : b_prod[QBITS-1:0];
      b_in.rem    = 10'd0;
      b_in.den    = a_den_ff;
      b_in.qneg   = (b_prod < 0) ^ a_neg_ff;
      b_in.side   = a_side_ff;
   end

   // ---------------- divider: one quotient bit per stage
   div_type dv_ff  [0:QBITS];
   logic    dvl_ff [0:QBITS];

   always_ff @(posedge clock) begin
      if (reset) dvl_ff[0] <= 1'b0;
      else if (adv) dvl_ff[0] <= a_vld_ff;
      if (adv) dv_ff[0] <= b_in;
   end

   for (genvar k = 0; k < QBITS; k++) begin : g_div
      div_type    nx;
      logic [10:0] trial;
      always_comb begin
         nx    = dv_ff[k];
         trial = {dv_ff[k].rem, dv_ff[k].work[QBITS-1]};
         if (trial >= {1'b0, dv_ff[k].den}) begin
            nx.rem  = 10'(trial - {1'b0, dv_ff[k].den});
            nx.work = {dv_ff[k].work[QBITS-2:0], 1'b1};
         end else begin
            nx.rem  = trial[9:0];
            nx.work = {dv_ff[k].work[QBITS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dvl_ff[k+1] <= 1'b0;
         else if (adv) dvl_ff[k+1] <= dvl_ff[k];
         if (adv) dv_ff[k+1] <= nx;
      end
   end

   // ---------------- stage p1: signed quotient, drive level, regen product
   logic signed [WIDE_W-1:0] p1_drive_in;
   logic signed [15:0]       p1_prod_in;

   always_comb begin
      logic signed [WIDE_W-1:0] qs;
      logic signed [7:0]        t;
      qs = dv_ff[QBITS].qneg ? -$signed({1'b0, dv_ff[QBITS].work})
                             :  $signed({1'b0, dv_ff[QBITS].work});
      p1_drive_in = qs + $signed({12'd0, dv_ff[QBITS].side.y0});
      t           = 8'sd100 - $signed({1'b0, dv_ff[QBITS].work[6:0]});
      p1_prod_in  = dv_ff[QBITS].side.rdiff * t;
   end

   logic                     p1_vld_ff;
   logic signed [WIDE_W-1:0] p1_drive_ff;
   logic signed [15:0]       p1_prod_ff;
   side_type                 p1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) p1_vld_ff <= 1'b0;
      else if (adv) p1_vld_ff <= dvl_ff[QBITS];
      if (adv) begin
         p1_drive_ff <= p1_drive_in;
         p1_prod_ff  <= p1_prod_in;
         p1_side_ff  <= dv_ff[QBITS].side;
      end
   end

   // ---------------- stage p2: regen scale by a tenth, level select
   logic signed [WIDE_W-1:0] p2_lvl_in;

   always_comb begin
      logic [14:0]        amag;
      logic [31:0]        scaled;
      logic [10:0]        tenth;
      logic signed [11:0] q10;
      amag   = (p1_prod_ff < 0) ? 15'(-p1_prod_ff) : p1_prod_ff[14:0];
      scaled = 32'(amag) * 32'd6554;   // times 2^16/10, exact below 16000
      tenth  = scaled[26:16];
      q10    = (p1_prod_ff < 0) ? -$signed({1'b0, tenth}) : $signed({1'b0, tenth});
      case (p1_side_ff.kind)
         KIND_CREEP: p2_lvl_in = $signed({11'd0, p1_side_ff.creep_lvl});
         KIND_REGEN: p2_lvl_in = -$signed(WIDE_W'(p1_side_ff.rlo) * WIDE_W'(10))
                                 - WIDE_W'(q10);
         KIND_DRIVE: p2_lvl_in = p1_drive_ff;
         default:    p2_lvl_in = '0;
      endcase
   end

   logic                     p2_vld_ff;
   logic signed [WIDE_W-1:0] p2_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) p2_vld_ff <= 1'b0;
      else if (adv) p2_vld_ff <= p1_vld_ff;
      if (adv) p2_lvl_ff <= p2_lvl_in;
   end

   // ---------------- output register: range fault and top snap
   logic               oor;
   logic signed [11:0] lvl_out_in;
   logic               o_vld_ff;
   logic signed [11:0] o_lvl_ff;
   logic               o_fault_ff;

   assign oor = (p2_lvl_ff > WIDE_W'(LIMIT_HI)) || (p2_lvl_ff < WIDE_W'(LIMIT_LO));

   always_comb begin
      if (oor)
         lvl_out_in = '0;
      else if (p2_lvl_ff > WIDE_W'(SNAP_FROM))
         lvl_out_in = 12'(FULL_LVL);
      else
         lvl_out_in = p2_lvl_ff[11:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
         fault_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= p2_vld_ff;
         if (p2_vld_ff && oor) fault_ff <= 1'b1;
      end
      if (adv) begin
         o_lvl_ff   <= lvl_out_in;
         o_fault_ff <= fault_ff | (p2_vld_ff & oor);
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {4'd0, o_lvl_ff};
   assign rsp_tuser  = o_fault_ff;

`ifndef ASSERT_OFF
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(fault_ff)) else $error("fault latch cleared");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (o_lvl_ff >= -12'sd1050) && (o_lvl_ff <= 12'sd1000))
      else $error("level out of range");
   a_snap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && o_lvl_ff > 12'sd979) |-> (o_lvl_ff == 12'sd1000))
      else $error("level not snapped to full");
   a_fault_seen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser[0]) |=> fault_ff)
      else $error("fault shown but not latched");
`endif

endmodule
